### design/assert_macros.svh
// assertion helpers shared by the allocator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every clock outside reset
`define BBA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same-cycle implication checked outside reset
`define BBA_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

### design/bba_pkg.sv
// ---------------------------------------------------------------------------
// bba_pkg
// shared constants, types and helpers of the buddy allocator
// ---------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  localparam int MAX_LEVELS  = 10;
  localparam int STACK_DEPTH = 16;

  localparam int PR_W      = 27;
  localparam int AL_W      = 17;
  localparam int LV_W      = 4;
  localparam int CFG_W     = 27;
  localparam int CFG_IDX_W = 2;
  localparam int REQ_W     = 32;
  localparam int OUT_W     = 27;

  localparam int NODE_W    = MAX_LEVELS + 1;
  localparam int MEM_DEPTH = 2 << MAX_LEVELS;
  localparam int LVL_W     = $clog2(MAX_LEVELS + 1);
  localparam int LF_W      = MAX_LEVELS + 1;
  localparam int PART_W    = PR_W + 1;
  localparam int SIZE_W    = (PART_W + MAX_LEVELS > REQ_W) ? PART_W + MAX_LEVELS : REQ_W + 1;
  localparam int SP_W      = $clog2(STACK_DEPTH + 1);
  localparam int SI_W      = $clog2(STACK_DEPTH);
  localparam int DCNT_W    = $clog2(PR_W + 1);

  localparam logic [SIZE_W-1:0] CAP_BYTES = SIZE_W'(100000000);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PARTITION_REQUEST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGNMENT         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVELS_IN_USE     = 2'd2;
  localparam int                   NUM_REGS              = 3;

  localparam logic [PR_W-1:0] RESET_PARTITION = PR_W'(256);
  localparam logic [AL_W-1:0] RESET_ALIGNMENT = AL_W'(256);
  localparam logic [LV_W-1:0] RESET_LEVELS    = LV_W'(10);

  // transaction codes
  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_FREE,
    ST_PARTIAL,
    ST_FULL
  } node_st_t;

  typedef struct packed {
    node_st_t        st;
    logic [LF_W-1:0] lf;
    logic            mark;
  } node_word_t;

  typedef enum logic [4:0] {
    S_DIV_INIT, S_DIV, S_PART, S_HEIGHT, S_SWEEP_INIT, S_SWEEP, S_IDLE,
    S_FIT, S_ROOT_RD, S_ROOT_PUSH, S_POP, S_RD_R, S_PUSH2, S_ALLOC,
    S_REL_RD, S_REL_CHK, S_REL_WR, S_FIX_RDL, S_FIX_RDR, S_FIX_WR,
    S_RESULT, S_EMIT
  } ctl_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_DIV_INIT, OP_DIV_STEP, OP_PART, OP_HEIGHT, OP_SWEEP_INIT,
    OP_SWEEP, OP_ACCEPT, OP_FIT, OP_ROOT_RD, OP_ROOT_PUSH, OP_POP, OP_RD_R,
    OP_PUSH2, OP_ALLOC_WR, OP_REL_RD, OP_REL_WR, OP_FIX_RDL, OP_FIX_RDR,
    OP_FIX_WR, OP_RESULT, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    logic div_last;
    logic height_ok;
    logic sweep_last;
    logic fit_more;
    logic fit_ok;
    logic stack_empty;
    logic top_found;
    logic top_expand;
    logic rel_valid;
    logic cur_root;
    logic fix_root;
    logic out_free;
  } dp_status_t;

  // tree depth of a node, root at zero
  function automatic logic [LVL_W-1:0] depth_of(input logic [NODE_W-1:0] i);
    logic [NODE_W:0]    v;
    logic [LVL_W-1:0]   d;
    v = {1'b0, i} + (NODE_W+1)'(1);
    d = '0;
    for (int b = 1; b <= NODE_W; b++) begin
      if (v[b]) d = LVL_W'(b);
    end
    return d;
  endfunction

endpackage

`default_nettype wire

### design/bba_datapath.sv
// ---------------------------------------------------------------------------
// bba_datapath
// node memory, walk stack, setup arithmetic and result registers
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bba_datapath import bba_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 func,
  input  logic [REQ_W-1:0]     request_bytes,
  input  logic [NODE_W-1:0]    node_number,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic                 ok,
  output logic [NODE_W-1:0]    block_node,
  output logic [OUT_W-1:0]     block_offset,
  output logic [OUT_W-1:0]     block_bytes,
  output logic [OUT_W-1:0]     occupied_bytes,
  output logic [OUT_W-1:0]     free_bytes,
  output logic [OUT_W-1:0]     largest_free_bytes,
  input  dp_op_t               op,
  output dp_status_t           status
);

  logic [PR_W-1:0]   cfg_pr;
  logic [AL_W-1:0]   cfg_al;
  logic [LV_W-1:0]   cfg_lv;

  logic [AL_W-1:0]   al_eff;
  logic [PR_W-1:0]   div_shift;
  logic [AL_W-1:0]   div_rem;
  logic [DCNT_W-1:0] div_cnt;
  logic [PART_W-1:0] part;
  logic [LVL_W-1:0]  height;
  logic [NODE_W-1:0] node_count;
  logic [NODE_W-1:0] sweep_idx;

  logic [REQ_W-1:0]  req_bytes;
  logic [LVL_W-1:0]  fit_k;
  logic [SIZE_W-1:0] fit_size;
  logic [LVL_W-1:0]  target;
  logic [NODE_W-1:0] cur;
  logic [NODE_W-1:0] fix;
  node_word_t        left_word;

  logic [NODE_W-1:0] stk_node [STACK_DEPTH];
  node_st_t          stk_st   [STACK_DEPTH];
  logic [SP_W-1:0]   sp;

  logic              res_ok;
  logic [OUT_W-1:0]  res_bytes;
  logic [OUT_W-1:0]  occ;
  logic [LF_W-1:0]   root_lf;
  logic [OUT_W-1:0]  res_offset;
  logic [OUT_W-1:0]  res_free;
  logic [OUT_W-1:0]  res_largest;

  node_word_t        mem [MEM_DEPTH];
  node_word_t        rdata;
  logic              mem_we;
  logic [NODE_W-1:0] mem_waddr;
  logic [NODE_W-1:0] mem_raddr;
  node_word_t        mem_wdata;

  // setup arithmetic
  logic [AL_W:0]      div_trial;
  logic [AL_W-1:0]    div_next;
  logic [PART_W-1:0]  part_calc;
  logic [LVL_W-1:0]   lv_min;
  logic [SIZE_W-1:0]  total_size;
  logic               over_cap;
  logic [NODE_W:0]    nc_full;

  assign div_trial = {div_rem, div_shift[PR_W-1]};
  always_comb begin
    if (div_trial >= {1'b0, al_eff}) div_next = AL_W'(div_trial - {1'b0, al_eff});
    else                             div_next = div_trial[AL_W-1:0];
  end
  assign part_calc = PART_W'(cfg_pr)
                   + ((div_rem != '0) ? PART_W'(al_eff - div_rem) : '0);
  assign lv_min = (32'(cfg_lv) > MAX_LEVELS) ? LVL_W'(MAX_LEVELS) : LVL_W'(cfg_lv);
  assign total_size = SIZE_W'(part) << height;
  assign over_cap = (height != '0) && (total_size > CAP_BYTES);
  assign nc_full = ((NODE_W+1)'(2) << height) - (NODE_W+1)'(1);

  // walk stack top
  logic [SP_W-1:0]   sp_m1;
  logic [SI_W-1:0]   top_idx;
  logic [NODE_W-1:0] top_node;
  node_st_t          top_st;
  logic [LVL_W-1:0]  top_d;
  logic              top_skip;
  logic              top_found;
  logic              top_expand;

  assign sp_m1      = sp - SP_W'(1);
  assign top_idx    = sp_m1[SI_W-1:0];
  assign top_node   = stk_node[top_idx];
  assign top_st     = stk_st[top_idx];
  assign top_d      = depth_of(top_node);
  assign top_skip   = (top_st == ST_FULL) || (top_d > target);
  assign top_found  = !top_skip && (top_st == ST_FREE) && (top_d == target);
  assign top_expand = !top_skip && !top_found && (top_d < height);

  // child and parent addresses
  logic [NODE_W-1:0] cur_left;
  logic [NODE_W-1:0] cur_right;
  logic [NODE_W-1:0] top_left;
  logic [NODE_W-1:0] fix_parent;
  logic [NODE_W-1:0] par_left;
  logic [NODE_W-1:0] fix_right;

  assign cur_left   = {cur[NODE_W-2:0], 1'b1};
  assign cur_right  = {cur[NODE_W-2:0], 1'b0} + NODE_W'(2);
  assign top_left   = {top_node[NODE_W-2:0], 1'b1};
  assign fix_parent = (fix - NODE_W'(1)) >> 1;
  assign par_left   = {fix_parent[NODE_W-2:0], 1'b1};
  assign fix_right  = {fix[NODE_W-2:0], 1'b0} + NODE_W'(2);

  // block geometry
  logic [LVL_W-1:0]  cur_d;
  logic [SIZE_W-1:0] cur_size;
  logic [OUT_W-1:0]  cur_bytes;
  logic [LF_W-1:0]   cur_own_lf;
  logic [LF_W-1:0]   fix_own_lf;
  logic [LF_W-1:0]   sweep_own_lf;
  logic [NODE_W-1:0] off_idx;
  logic [OUT_W+NODE_W-1:0] off_prod;
  logic [LF_W+PART_W-1:0]  lf_prod;

  assign cur_d        = depth_of(cur);
  assign cur_size     = SIZE_W'(part) << (height - cur_d);
  assign cur_bytes    = cur_size[OUT_W-1:0];
  assign cur_own_lf   = LF_W'(1) << (height - cur_d);
  assign fix_own_lf   = LF_W'(1) << (height - depth_of(fix));
  assign sweep_own_lf = LF_W'(1) << (height - depth_of(sweep_idx));
  assign off_idx      = cur + NODE_W'(1) - (NODE_W'(1) << cur_d);
  assign off_prod     = res_bytes * off_idx;
  assign lf_prod      = root_lf * part;

  // parent recompute from its two children
  node_word_t merged;
  always_comb begin
    merged.mark = 1'b0;
    if (left_word.st == ST_FULL && rdata.st == ST_FULL) begin
      merged.st = ST_FULL;
      merged.lf = '0;
    end else if (left_word.st == ST_FREE && rdata.st == ST_FREE) begin
      merged.st = ST_FREE;
      merged.lf = fix_own_lf;
    end else begin
      merged.st = ST_PARTIAL;
      merged.lf = (left_word.lf > rdata.lf) ? left_word.lf : rdata.lf;
    end
  end

  // up to two pushes in the same cycle; a full child is not pushed, and a push is dropped when the stack is full
  logic            push_r;
  logic            push_l;
  logic [SP_W-1:0] sp_r;

  assign push_r = (rdata.st != ST_FULL) && (32'(sp) < STACK_DEPTH);
  assign sp_r   = sp + SP_W'(push_r);
  assign push_l = (left_word.st != ST_FULL) && (32'(sp_r) < STACK_DEPTH);

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur;
    mem_wdata = '0;
    mem_raddr = cur;
    case (op)
      OP_SWEEP: begin
        mem_we       = 1'b1;
        mem_waddr    = sweep_idx;
        mem_wdata.st = ST_FREE;
        mem_wdata.lf = sweep_own_lf;
      end
      OP_ROOT_RD:  mem_raddr = '0;
      OP_POP:      mem_raddr = top_left;
      OP_RD_R:     mem_raddr = cur_right;
      OP_ALLOC_WR: begin
        mem_we         = 1'b1;
        mem_wdata.st   = ST_FULL;
        mem_wdata.mark = 1'b1;
      end
      OP_REL_WR: begin
        mem_we       = 1'b1;
        mem_wdata.st = ST_FREE;
        mem_wdata.lf = cur_own_lf;
      end
      OP_FIX_RDL:  mem_raddr = par_left;
      OP_FIX_RDR:  mem_raddr = fix_right;
      OP_FIX_WR: begin
        mem_we    = 1'b1;
        mem_waddr = fix;
        mem_wdata = merged;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[mem_raddr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_pr <= RESET_PARTITION;
      cfg_al <= RESET_ALIGNMENT;
      cfg_lv <= RESET_LEVELS;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PARTITION_REQUEST: cfg_pr <= cfg_data[PR_W-1:0];
        REG_ALIGNMENT:         cfg_al <= cfg_data[AL_W-1:0];
        REG_LEVELS_IN_USE:     cfg_lv <= cfg_data[LV_W-1:0];
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      case (op)
        OP_ROOT_RD:   sp <= '0;
        OP_ROOT_PUSH: sp <= SP_W'(1);
        OP_POP:       sp <= sp_m1;
        OP_PUSH2:     sp <= sp_r + SP_W'(push_l);
        default: ;
      endcase
      if (op == OP_EMIT)  out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // stack storage
  always_ff @(posedge clk) begin
    if (op == OP_ROOT_PUSH) begin
      stk_node[0] <= '0;
      stk_st[0]   <= rdata.st;
    end else if (op == OP_PUSH2) begin
      if (push_r) begin
        stk_node[sp[SI_W-1:0]] <= cur_right;
        stk_st[sp[SI_W-1:0]]   <= rdata.st;
      end
      if (push_l) begin
        stk_node[sp_r[SI_W-1:0]] <= cur_left;
        stk_st[sp_r[SI_W-1:0]]   <= left_word.st;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (mem_we && mem_waddr == '0) root_lf <= mem_wdata.lf;
    case (op)
      OP_DIV_INIT: begin
        al_eff    <= (cfg_al == '0) ? AL_W'(1) : cfg_al;
        div_shift <= cfg_pr;
        div_rem   <= '0;
        div_cnt   <= DCNT_W'(PR_W);
      end
      OP_DIV_STEP: begin
        div_rem   <= div_next;
        div_shift <= div_shift << 1;
        div_cnt   <= div_cnt - DCNT_W'(1);
      end
      OP_PART: begin
        part   <= part_calc;
        height <= lv_min;
      end
      OP_HEIGHT: begin
        if (over_cap) height <= height - LVL_W'(1);
      end
      OP_SWEEP_INIT: begin
        sweep_idx  <= '0;
        node_count <= nc_full[NODE_W-1:0];
        occ        <= '0;
      end
      OP_SWEEP: sweep_idx <= sweep_idx + NODE_W'(1);
      OP_ACCEPT: begin
        req_bytes <= request_bytes;
        cur       <= node_number;
        fit_k     <= '0;
        fit_size  <= SIZE_W'(part);
        res_ok    <= 1'b0;
        res_bytes <= '0;
        if (func == FUNC_RELEASE) fit_k <= '0;
      end
      OP_FIT: begin
        if (status.fit_more) begin
          fit_k    <= fit_k + LVL_W'(1);
          fit_size <= fit_size << 1;
        end
      end
      OP_ROOT_RD: target <= height - fit_k;
      OP_POP:     cur <= top_node;
      OP_RD_R:    left_word <= rdata;
      OP_ALLOC_WR: begin
        res_ok    <= 1'b1;
        res_bytes <= cur_bytes;
        occ       <= occ + cur_bytes;
        fix       <= cur;
      end
      OP_REL_WR: begin
        res_ok    <= 1'b1;
        res_bytes <= cur_bytes;
        occ       <= occ - cur_bytes;
        fix       <= cur;
      end
      OP_FIX_RDL: fix <= fix_parent;
      OP_FIX_RDR: left_word <= rdata;
      OP_RESULT: begin
        res_offset  <= off_prod[OUT_W-1:0];
        res_largest <= lf_prod[OUT_W-1:0];
        res_free    <= total_size[OUT_W-1:0] - occ;
      end
      OP_EMIT: begin
        ok                 <= res_ok;
        block_node         <= res_ok ? cur : '0;
        block_offset       <= res_ok ? res_offset : '0;
        block_bytes        <= res_bytes;
        occupied_bytes     <= occ;
        free_bytes         <= res_free;
        largest_free_bytes <= res_largest;
      end
      default: ;
    endcase
  end

  // status toward the controller
  assign status.div_last    = (div_cnt == DCNT_W'(1));
  assign status.height_ok   = !over_cap;
  assign status.sweep_last  = (sweep_idx == node_count - NODE_W'(1));
  assign status.fit_more    = (fit_k < height) && (fit_size < SIZE_W'(req_bytes));
  assign status.fit_ok      = (fit_size >= SIZE_W'(req_bytes));
  assign status.stack_empty = (sp == '0);
  assign status.top_found   = top_found;
  assign status.top_expand  = top_expand;
  assign status.rel_valid   = (cur < node_count) && rdata.mark;
  assign status.cur_root    = (cur == '0);
  assign status.fix_root    = (fix == '0);
  assign status.out_free    = !out_valid || !out_stall;

  `BBA_ASSERT(a_stack_bound, (32'(sp) <= STACK_DEPTH), "walk stack pointer out of range")
  `BBA_ASSERT_IMPL(a_node_in_tree, out_valid && ok, block_node < node_count, "node outside tree")
  `BBA_ASSERT_IMPL(a_fix_after_write, op == OP_FIX_RDL, fix != '0, "fixup climbed past root")

endmodule

`default_nettype wire

### design/bba_ctrl.sv
// ---------------------------------------------------------------------------
// bba_ctrl
// sequencer of setup, tree walk, release and upward fix
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bba_ctrl import bba_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 func,
  input  dp_status_t           status,
  output dp_op_t               op
);

  ctl_state_t state, state_next;
  logic       cfg_hit;

  assign cfg_hit  = cfg_write && (32'(cfg_index) < NUM_REGS);
  assign in_stall = (state != S_IDLE) || cfg_write;

  always_ff @(posedge clk) begin
    if (rst) state <= S_DIV_INIT;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_DIV_INIT:   state_next = S_DIV;
      S_DIV:        if (status.div_last) state_next = S_PART;
      S_PART:       state_next = S_HEIGHT;
      S_HEIGHT:     if (status.height_ok) state_next = S_SWEEP_INIT;
      S_SWEEP_INIT: state_next = S_SWEEP;
      S_SWEEP:      if (status.sweep_last) state_next = S_IDLE;
      S_IDLE: begin
        // a config write stalls the input, so no transaction is taken then
        if (in_valid && !cfg_write) begin
          state_next = (func == FUNC_RELEASE) ? S_REL_RD : S_FIT;
        end
      end
      S_FIT: begin
        if (!status.fit_more) state_next = status.fit_ok ? S_ROOT_RD : S_RESULT;
      end
      S_ROOT_RD:    state_next = S_ROOT_PUSH;
      S_ROOT_PUSH:  state_next = S_POP;
      S_POP: begin
        if (status.stack_empty)     state_next = S_RESULT;
        else if (status.top_found)  state_next = S_ALLOC;
        else if (status.top_expand) state_next = S_RD_R;
      end
      S_RD_R:       state_next = S_PUSH2;
      S_PUSH2:      state_next = S_POP;
      S_ALLOC:      state_next = status.cur_root ? S_RESULT : S_FIX_RDL;
      S_REL_RD:     state_next = S_REL_CHK;
      S_REL_CHK:    state_next = status.rel_valid ? S_REL_WR : S_RESULT;
      S_REL_WR:     state_next = status.cur_root ? S_RESULT : S_FIX_RDL;
      S_FIX_RDL:    state_next = S_FIX_RDR;
      S_FIX_RDR:    state_next = S_FIX_WR;
      S_FIX_WR:     state_next = status.fix_root ? S_RESULT : S_FIX_RDL;
      S_RESULT:     state_next = S_EMIT;
      S_EMIT:       if (status.out_free) state_next = S_IDLE;
      default:      state_next = S_DIV_INIT;
    endcase
    if (cfg_hit) state_next = S_DIV_INIT;
  end

  always_comb begin
    op = OP_NONE;
    case (state)
      S_DIV_INIT:   op = OP_DIV_INIT;
      S_DIV:        op = OP_DIV_STEP;
      S_PART:       op = OP_PART;
      S_HEIGHT:     op = OP_HEIGHT;
      S_SWEEP_INIT: op = OP_SWEEP_INIT;
      S_SWEEP:      op = OP_SWEEP;
      S_IDLE:       if (in_valid && !cfg_write) op = OP_ACCEPT;
      S_FIT:        op = OP_FIT;
      S_ROOT_RD:    op = OP_ROOT_RD;
      S_ROOT_PUSH:  op = OP_ROOT_PUSH;
      S_POP:        if (!status.stack_empty) op = OP_POP;
      S_RD_R:       op = OP_RD_R;
      S_PUSH2:      op = OP_PUSH2;
      S_ALLOC:      op = OP_ALLOC_WR;
      S_REL_RD:     op = OP_REL_RD;
      S_REL_WR:     op = OP_REL_WR;
      S_FIX_RDL:    op = OP_FIX_RDL;
      S_FIX_RDR:    op = OP_FIX_RDR;
      S_FIX_WR:     op = OP_FIX_WR;
      S_RESULT:     op = OP_RESULT;
      S_EMIT:       if (status.out_free) op = OP_EMIT;
      default:      op = OP_NONE;
    endcase
  end

  `BBA_ASSERT(a_busy_after_accept, (in_valid && !in_stall) |=> state != S_IDLE, "idle after accept")

endmodule

`default_nettype wire

### design/binary_buddy_allocator.sv
// ---------------------------------------------------------------------------
// binary_buddy_allocator
// buddy allocator over a complete binary tree of up to 2047 nodes
// ---------------------------------------------------------------------------
// usage
//   config: write partition_request (0), alignment (1) or levels_in_use (2)
//     with cfg_write high; each write rebuilds the tree, as reset does
//   input channel: in_valid/in_stall carry func, request_bytes, node_number;
//     a transaction is taken when in_valid is high and in_stall is low
//   output channel: out_valid/out_stall carry one result per transaction
// sequence
//   rebuild after reset or a config write: remainder division, a height
//     search, then one node memory write per tree node (2047 at full
//     height), with in_stall high
//   allocate: fit steps (one per size doubling), a depth walk over the
//     visited nodes, then an upward fix per tree level; the node memory,
//     with one read port and one write port, sets the pace
//   release: a mark check, then an upward fix per tree level above the node
//   one transaction at a time; the result register lets the next transaction
//     start while a result waits under out_stall, and the block holds its
//     finished result until the output register drains
// ---------------------------------------------------------------------------
`default_nettype none

module binary_buddy_allocator import bba_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 func,
  input  logic [REQ_W-1:0]     request_bytes,
  input  logic [NODE_W-1:0]    node_number,
  // output channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 ok,
  output logic [NODE_W-1:0]    block_node,
  output logic [OUT_W-1:0]     block_offset,
  output logic [OUT_W-1:0]     block_bytes,
  output logic [OUT_W-1:0]     occupied_bytes,
  output logic [OUT_W-1:0]     free_bytes,
  output logic [OUT_W-1:0]     largest_free_bytes
);

  // command from the sequencer, flags back from the datapath
  dp_op_t     op;
  dp_status_t status;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .status    (status),
    .op        (op)
  );

  // node memory, walk stack and result registers
  bba_datapath u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .func               (func),
    .request_bytes      (request_bytes),
    .node_number        (node_number),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .ok                 (ok),
    .block_node         (block_node),
    .block_offset       (block_offset),
    .block_bytes        (block_bytes),
    .occupied_bytes     (occupied_bytes),
    .free_bytes         (free_bytes),
    .largest_free_bytes (largest_free_bytes),
    .op                 (op),
    .status             (status)
  );

endmodule

`default_nettype wire

### bench/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// self-checking bench of the buddy allocator: a behavioral model of the
// node tree predicts each result, a checker compares every output field
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
  import bba_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // expected result of one transaction
  typedef struct {
    logic              ok;
    logic [NODE_W-1:0] node;
    logic [OUT_W-1:0]  offset;
    logic [OUT_W-1:0]  bytes;
    logic [OUT_W-1:0]  occupied;
    logic [OUT_W-1:0]  free;
    logic [OUT_W-1:0]  largest;
  } alloc_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 func = FUNC_ALLOC;
  logic [REQ_W-1:0]     request_bytes = '0;
  logic [NODE_W-1:0]    node_number = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 ok;
  logic [NODE_W-1:0]    block_node;
  logic [OUT_W-1:0]     block_offset;
  logic [OUT_W-1:0]     block_bytes;
  logic [OUT_W-1:0]     occupied_bytes;
  logic [OUT_W-1:0]     free_bytes;
  logic [OUT_W-1:0]     largest_free_bytes;

  binary_buddy_allocator dut (.*);

  always #5 clk = ~clk;

  // ---- tree model state ----
  logic [PR_W-1:0] m_part_req;
  logic [AL_W-1:0] m_align;
  logic [LV_W-1:0] m_levels;
  longint unsigned m_part;       // aligned partition size in bytes
  int              m_height;
  int              m_count;      // nodes in the tree
  node_st_t        m_status [MEM_DEPTH];
  int unsigned     m_largest [MEM_DEPTH];
  bit              m_mark [MEM_DEPTH];
  logic [OUT_W-1:0] m_occupied;

  alloc_result_t   pending_results[$];
  int              live_blocks[$];  // nodes handed out and not yet released
  bit              failed = 1'b0;
  bit              idle_on = 1'b1;  // random idling enabled

  function automatic int node_depth(int i);
    int v;
    int d;
    v = i + 1;
    d = 0;
    while (v > 1) begin
      v = v >> 1;
      d++;
    end
    return d;
  endfunction

  function automatic void tree_rebuild();
    longint unsigned a;
    int h;
    a = (m_align == 0) ? 1 : m_align;
    h = (m_levels < MAX_LEVELS) ? m_levels : MAX_LEVELS;
    m_part = ((longint'(m_part_req) + a - 1) / a) * a;
    while (h > 0 && (m_part << h) > 100000000) h--;
    m_height = h;
    m_count = (2 << h) - 1;
    for (int i = 0; i < MEM_DEPTH; i++) begin
      m_status[i] = ST_FREE;
      m_mark[i] = 1'b0;
      m_largest[i] = (i < m_count) ? (1 << (h - node_depth(i))) : 0;
    end
    m_occupied = '0;
    live_blocks.delete();
  endfunction

  function automatic longint unsigned block_size(int i);
    return m_part << (m_height - node_depth(i));
  endfunction

  function automatic longint unsigned block_start(int i);
    int d;
    d = node_depth(i);
    return ((m_part << m_height) >> d) * longint'(i + 1 - (1 << d));
  endfunction

  // recompute ancestors from node i up to the root
  function automatic void fix_ancestors(int i);
    int l;
    int r;
    while (i > 0) begin
      i = (i - 1) / 2;
      l = 2 * i + 1;
      r = l + 1;
      if (m_status[l] == ST_FULL && m_status[r] == ST_FULL) begin
        m_status[i] = ST_FULL;
        m_largest[i] = 0;
      end else if (m_status[l] == ST_FREE && m_status[r] == ST_FREE) begin
        m_status[i] = ST_FREE;
        m_largest[i] = 1 << (m_height - node_depth(i));
      end else begin
        m_status[i] = ST_PARTIAL;
        m_largest[i] = (m_largest[l] > m_largest[r]) ? m_largest[l] : m_largest[r];
      end
    end
  endfunction

  // left-first depth walk with a bounded stack; candidates past its top are dropped
  function automatic int find_free(int target);
    int stk [STACK_DEPTH];
    int sp;
    int i;
    int d;
    int l;
    sp = 1;
    stk[0] = 0;
    while (sp > 0) begin
      sp--;
      i = stk[sp];
      if (i >= m_count || m_status[i] == ST_FULL) continue;
      d = node_depth(i);
      if (d > target) continue;
      if (m_status[i] == ST_FREE && d == target) return i;
      if (d < m_height) begin
        l = 2 * i + 1;
        if (m_status[l+1] != ST_FULL && sp < STACK_DEPTH) begin
          stk[sp] = l + 1;
          sp++;
        end
        if (m_status[l] != ST_FULL && sp < STACK_DEPTH) begin
          stk[sp] = l;
          sp++;
        end
      end
    end
    return -1;
  endfunction

  function automatic alloc_result_t predict_alloc(logic f, logic [REQ_W-1:0] req,
                                                  logic [NODE_W-1:0] nn);
    alloc_result_t r;
    int k;
    int n;
    longint unsigned sz;
    r = '{default: '0};
    if (f == FUNC_ALLOC) begin
      k = 0;
      while (k < m_height && (m_part << k) < req) k++;
      if ((m_part << k) >= req) begin
        n = find_free(m_height - k);
        if (n >= 0) begin
          m_status[n] = ST_FULL;
          m_largest[n] = 0;
          m_mark[n] = 1'b1;
          fix_ancestors(n);
          sz = block_size(n);
          m_occupied = OUT_W'(m_occupied + sz);
          r.ok = 1'b1;
          r.node = NODE_W'(n);
          r.offset = OUT_W'(block_start(n));
          r.bytes = OUT_W'(sz);
          live_blocks.insert(live_blocks.size(), n);
        end
      end
    end else if (nn < m_count && m_mark[nn]) begin
      n = nn;
      m_mark[n] = 1'b0;
      sz = block_size(n);
      m_occupied = OUT_W'(m_occupied - sz);
      m_status[n] = ST_FREE;
      m_largest[n] = 1 << (m_height - node_depth(n));
      fix_ancestors(n);
      r.ok = 1'b1;
      r.node = NODE_W'(n);
      r.offset = OUT_W'(block_start(n));
      r.bytes = OUT_W'(sz);
      foreach (live_blocks[j]) if (live_blocks[j] == n) begin
        live_blocks.delete(j);
        break;
      end
    end
    r.occupied = m_occupied;
    r.free = OUT_W'((m_part << m_height) - m_occupied);
    r.largest = OUT_W'(longint'(m_largest[0]) * m_part);
    return r;
  endfunction

  // ---- driving ----
  task automatic send_item(logic f, logic [REQ_W-1:0] req, logic [NODE_W-1:0] nn);
    @(negedge clk);
    // random gap before the transaction
    while (idle_on && $urandom_range(99) < 20) @(negedge clk);
    func <= f;
    request_bytes <= req;
    node_number <= nn;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_results.insert(pending_results.size(), predict_alloc(f, req, nn));
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // registers change only with no transaction result outstanding
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_PARTITION_REQUEST) m_part_req = PR_W'(val);
    else if (idx == REG_ALIGNMENT) m_align = AL_W'(val);
    else m_levels = LV_W'(val);
    tree_rebuild();
  endtask

  task automatic set_config(int unsigned pr, int unsigned al, int unsigned lv);
    write_reg(REG_PARTITION_REQUEST, CFG_W'(pr));
    write_reg(REG_ALIGNMENT, CFG_W'(al));
    write_reg(REG_LEVELS_IN_USE, CFG_W'(lv));
  endtask

  function automatic logic [REQ_W-1:0] fitting_request();
    longint unsigned sz;
    sz = m_part << $urandom_range(m_height, 0);
    if ($urandom_range(3) == 0) return REQ_W'(sz);
    return REQ_W'(sz - ((sz > 1) ? $urandom_range(int'(sz / 2)) : 0));
  endfunction

  // ---- checking ----
  always @(negedge clk) out_stall <= idle_on && ($urandom_range(99) < 20);

  always @(posedge clk) begin
    alloc_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, got node %0d", $time, block_node);
        failed = 1'b1;
      end else begin
        e = pending_results.pop_front();
        if ({ok, block_node, block_offset, block_bytes, occupied_bytes, free_bytes,
             largest_free_bytes} !== {e.ok, e.node, e.offset, e.bytes, e.occupied,
                                      e.free, e.largest}) begin
          $display("%0t: expected ok %0d node %0d off %0d bytes %0d occ %0d free %0d lf %0d",
                   $time, e.ok, e.node, e.offset, e.bytes, e.occupied, e.free, e.largest);
          $display("%0t: actual   ok %0d node %0d off %0d bytes %0d occ %0d free %0d lf %0d",
                   $time, ok, block_node, block_offset, block_bytes, occupied_bytes,
                   free_bytes, largest_free_bytes);
          failed = 1'b1;
        end
      end
    end
  end

  // ---- tests ----
  // default tree: fits, exact sizes, oversized, invalid and double release
  task automatic test_defaults();
    send_item(FUNC_ALLOC, 32'd0, '0);
    send_item(FUNC_ALLOC, 32'd1, '1);
    send_item(FUNC_ALLOC, 32'd257, '0);
    send_item(FUNC_ALLOC, 32'hFFFF_FFFF, '0);
    send_item(FUNC_ALLOC, 32'd262144, '0);
    send_item(FUNC_ALLOC, 32'd131072, '0);
    send_item(FUNC_RELEASE, '0, 11'd2047);
    send_item(FUNC_RELEASE, '1, 11'd0);
    send_item(FUNC_RELEASE, '0, 11'd1023);
    send_item(FUNC_RELEASE, '0, 11'd1024);
    send_item(FUNC_RELEASE, '0, 11'd1024);
    send_item(FUNC_ALLOC, 32'd200, '0);
  endtask

  // extreme settings: single node, zero partition, zero alignment, capped height
  task automatic test_config_extremes();
    set_config(1, 1, 0);
    send_item(FUNC_ALLOC, 32'd1, '0);
    send_item(FUNC_ALLOC, 32'd1, '0);
    send_item(FUNC_RELEASE, '0, 11'd0);
    set_config(0, 0, 2);
    send_item(FUNC_ALLOC, 32'd0, '0);
    send_item(FUNC_ALLOC, 32'd1, '0);
    set_config(27'h7FF_FFFF, 17'h1_FFFF, 15);
    send_item(FUNC_ALLOC, 32'd5, '0);
    set_config(67108864, 65536, 10);
    send_item(FUNC_ALLOC, 32'd67108864, '0);
    set_config(100, 64, 3);
    repeat (9) send_item(FUNC_ALLOC, 32'd128, '0);
  endtask

  // mostly fitting allocates and releases of live blocks, some noise
  task automatic test_random_traffic();
    int pick;
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 4) idle_on = 1'b0;
      if (phase == 5) idle_on = 1'b1;
      case ($urandom_range(3))
        0: set_config($urandom_range(4096, 1), $urandom_range(512, 0), $urandom_range(6, 0));
        1: set_config($urandom_range(1 << 20, 0), $urandom_range(65536, 1),
                      $urandom_range(15, 0));
        2: write_reg(REG_LEVELS_IN_USE, CFG_W'($urandom_range(15)));
        default: write_reg(REG_ALIGNMENT, CFG_W'($urandom_range(32, 1)));
      endcase
      for (int n = 0; n < 125; n++) begin
        pick = $urandom_range(99);
        if (pick < 55)
          send_item(FUNC_ALLOC, fitting_request(), NODE_W'($urandom));
        else if (pick < 85 && live_blocks.size() != 0)
          send_item(FUNC_RELEASE, REQ_W'($urandom),
                    NODE_W'(live_blocks[$urandom_range(live_blocks.size() - 1)]));
        else
          send_item(logic'($urandom_range(1)), REQ_W'($urandom), NODE_W'($urandom));
      end
    end
  endtask

  initial begin
    m_part_req = RESET_PARTITION;
    m_align = RESET_ALIGNMENT;
    m_levels = RESET_LEVELS;
    tree_rebuild();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_defaults();
    test_config_extremes();
    test_random_traffic();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (!failed && pending_results.size() == 0) begin
      $display("** binary_buddy_allocator: PASSED **");
    end else begin
      $display("** binary_buddy_allocator: FAILED **");
    end
    $finish;
  end

  // hang guard, well above a run of long tree walks
  initial begin
    #200ms;
    $display("** binary_buddy_allocator: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
+incdir+design
design/bba_pkg.sv
design/bba_datapath.sv
design/bba_ctrl.sv
design/binary_buddy_allocator.sv
bench/testbench.sv
